FILE: design/sahp_pkg.sv
// Shared types, constants and register codes for the stepper axis homing positioner.
package sahp_pkg;

  // Datapath widths
  localparam int unsigned POS_W = 16;
  localparam int unsigned TMR_W = 16;
  localparam int unsigned SPM_W = 10;
  localparam int unsigned MM_W  = 16;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned PROD_W = MM_W + SPM_W;

  localparam logic [TMR_W-1:0] TMR_MAX = {TMR_W{1'b1}};

  // Configuration reset values
  localparam logic [SPM_W-1:0] RST_STEP_SCALE    = SPM_W'(80);
  localparam logic [POS_W-1:0] RST_TRAVEL_LIMIT  = POS_W'(16000);
  localparam logic [TMR_W-1:0] RST_RUN_INTERVAL  = TMR_W'(312);
  localparam logic [TMR_W-1:0] RST_SEEK_INTERVAL = TMR_W'(833);
  localparam logic [TMR_W-1:0] RST_FEED_INTERVAL = TMR_W'(4166);
  localparam logic [POS_W-1:0] RST_BACKOFF_LEN   = POS_W'(160);
  localparam logic [TMR_W-1:0] RST_SETTLE_TICKS  = TMR_W'(50000);

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_STEP_SCALE    = 3'd0,
    CFG_TRAVEL_LIMIT  = 3'd1,
    CFG_RUN_INTERVAL  = 3'd2,
    CFG_SEEK_INTERVAL = 3'd3,
    CFG_FEED_INTERVAL = 3'd4,
    CFG_BACKOFF_LEN   = 3'd5,
    CFG_SETTLE_TICKS  = 3'd6,
    CFG_DIR_FLIP      = 3'd7
  } cfg_idx_t;

  // Homing sequence and normal running
  typedef enum logic [2:0] {
    PH_SEEK    = 3'd0,
    PH_SETTLE1 = 3'd1,
    PH_PULL1   = 3'd2,
    PH_SETTLE2 = 3'd3,
    PH_FEED    = 3'd4,
    PH_SETTLE3 = 3'd5,
    PH_PULL2   = 3'd6,
    PH_READY   = 3'd7
  } phase_t;

  // Item actions
  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_COMMAND = 1'b1;

  typedef struct packed {
    logic [SPM_W-1:0] step_scale;
    logic [POS_W-1:0] travel_limit;
    logic [TMR_W-1:0] run_interval;
    logic [TMR_W-1:0] seek_interval;
    logic [TMR_W-1:0] feed_interval;
    logic [POS_W-1:0] backoff_len;
    logic [TMR_W-1:0] settle_ticks;
    logic             dir_flip;
  } cfg_t;

  typedef struct packed {
    logic            action;
    logic [MM_W-1:0] position_mm;
    logic            limit_pressed;
  } in_t;

  typedef struct packed {
    logic             step_pulse;
    logic             dir_level;
    logic             is_homed;
    logic [2:0]       homing_phase;
    logic [POS_W-1:0] position_steps;
    logic [POS_W-1:0] target_position;
  } out_t;

endpackage

FILE: design/sahp_cfg_regs.sv
// Configuration register bank with reset defaults.
module sahp_cfg_regs
  import sahp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  // Write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_scale    <= RST_STEP_SCALE;
      cfg.travel_limit  <= RST_TRAVEL_LIMIT;
      cfg.run_interval  <= RST_RUN_INTERVAL;
      cfg.seek_interval <= RST_SEEK_INTERVAL;
      cfg.feed_interval <= RST_FEED_INTERVAL;
      cfg.backoff_len   <= RST_BACKOFF_LEN;
      cfg.settle_ticks  <= RST_SETTLE_TICKS;
      cfg.dir_flip      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STEP_SCALE:    cfg.step_scale    <= cfg_data[SPM_W-1:0];
        CFG_TRAVEL_LIMIT:  cfg.travel_limit  <= cfg_data[POS_W-1:0];
        CFG_RUN_INTERVAL:  cfg.run_interval  <= cfg_data[TMR_W-1:0];
        CFG_SEEK_INTERVAL: cfg.seek_interval <= cfg_data[TMR_W-1:0];
        CFG_FEED_INTERVAL: cfg.feed_interval <= cfg_data[TMR_W-1:0];
        CFG_BACKOFF_LEN:   cfg.backoff_len   <= cfg_data[POS_W-1:0];
        CFG_SETTLE_TICKS:  cfg.settle_ticks  <= cfg_data[TMR_W-1:0];
        CFG_DIR_FLIP:      cfg.dir_flip      <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: design/stepper_axis_homing_positioner_core.sv
// Top level: step/dir axis controller with two-touch homing.
// An accepted item passes from the input register to the result register, which holds its result.
// Throughput: one item per cycle while out_ready does not stall the result register; the axis
// state is updated in one pass as each item moves from the input register to the result register.
// Reset (synchronous, rst high): homing restarts at fast seek, position and target clear,
// the step timer saturates so the first step is immediate, registers take their defaults.
module stepper_axis_homing_positioner_core
  import sahp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_item,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_t cfg;

  // Input register
  in_t  in_q;
  logic in_q_valid;

  // Axis state
  phase_t           phase,         phase_next;
  logic [POS_W-1:0] cur_pos,       cur_pos_next;
  logic [POS_W-1:0] tgt_pos,       tgt_pos_next;
  logic [TMR_W-1:0] tick_cnt,      tick_cnt_next;
  logic [POS_W-1:0] pulloff_cnt,   pulloff_cnt_next;

  logic out_adv;
  logic fire;

  // Shared conditions
  logic [TMR_W-1:0]  cnt_inc;
  logic              reach_seek, reach_feed, reach_settle, reach_run;
  logic              pull_done, moving, positive;
  logic [PROD_W-1:0] prod;
  logic [POS_W-1:0]  cmd_steps;

  // Output values
  logic step, dir;

  sahp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake
  assign out_adv  = !out_valid || out_ready;
  assign in_ready = !in_q_valid || out_adv;
  assign fire     = in_q_valid && out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_item;
    end
  end

  // Timer and comparisons
  assign cnt_inc      = (tick_cnt == TMR_MAX) ? TMR_MAX : tick_cnt + TMR_W'(1);
  assign reach_seek   = (cnt_inc >= cfg.seek_interval)  || (cnt_inc == TMR_MAX);
  assign reach_feed   = (cnt_inc >= cfg.feed_interval)  || (cnt_inc == TMR_MAX);
  assign reach_settle = (cnt_inc >= cfg.settle_ticks)   || (cnt_inc == TMR_MAX);
  assign reach_run    = (cnt_inc >= cfg.run_interval)   || (cnt_inc == TMR_MAX);
  assign pull_done    = pulloff_cnt >= cfg.backoff_len;
  assign moving       = cur_pos != tgt_pos;
  assign positive     = tgt_pos > cur_pos;

  // mm to steps, saturated at the soft limit (which never exceeds the position range)
  assign prod      = PROD_W'(in_q.position_mm) * PROD_W'(cfg.step_scale);
  assign cmd_steps = (prod > PROD_W'(cfg.travel_limit)) ? cfg.travel_limit : prod[POS_W-1:0];

  // Next state
  always_comb begin
    phase_next       = phase;
    cur_pos_next     = cur_pos;
    tgt_pos_next     = tgt_pos;
    tick_cnt_next    = tick_cnt;
    pulloff_cnt_next = pulloff_cnt;
    if (in_q.action == ACT_COMMAND) begin
      if (phase == PH_READY) begin
        tgt_pos_next = cmd_steps;
      end
    end else begin
      tick_cnt_next = cnt_inc;
      case (phase)
        PH_SEEK, PH_FEED: begin
          if (in_q.limit_pressed) begin
            phase_next    = (phase == PH_SEEK) ? PH_SETTLE1 : PH_SETTLE3;
            tick_cnt_next = '0;
          end else if ((phase == PH_SEEK) ? reach_seek : reach_feed) begin
            tick_cnt_next = '0;
          end
        end
        PH_SETTLE1, PH_SETTLE2, PH_SETTLE3: begin
          if (reach_settle) begin
            phase_next       = phase_t'(phase + 3'd1);
            tick_cnt_next    = TMR_MAX;
            pulloff_cnt_next = '0;
          end
        end
        PH_PULL1, PH_PULL2: begin
          if (pull_done) begin
            if (phase == PH_PULL1) begin
              phase_next    = PH_SETTLE2;
              tick_cnt_next = '0;
            end else begin
              phase_next    = PH_READY;
              cur_pos_next  = cfg.backoff_len;
              tgt_pos_next  = cfg.backoff_len;
              tick_cnt_next = TMR_MAX;
            end
          end else if (reach_seek) begin
            pulloff_cnt_next = pulloff_cnt + POS_W'(1);
            tick_cnt_next    = '0;
          end
        end
        default: begin
          if (moving && reach_run) begin
            if (!positive && in_q.limit_pressed) begin
              // move toward the switch abandoned
              tgt_pos_next = cur_pos;
            end else begin
              cur_pos_next  = positive ? cur_pos + POS_W'(1) : cur_pos - POS_W'(1);
              tick_cnt_next = '0;
            end
          end
        end
      endcase
    end
  end

  // Step pulse and direction level
  always_comb begin
    step = 1'b0;
    dir  = 1'b0;
    if (in_q.action == ACT_TICK) begin
      case (phase)
        PH_SEEK, PH_FEED: begin
          step = !in_q.limit_pressed && ((phase == PH_SEEK) ? reach_seek : reach_feed);
        end
        PH_PULL1, PH_PULL2: begin
          step = !pull_done && reach_seek;
        end
        PH_READY: begin
          step = moving && reach_run && (positive || !in_q.limit_pressed);
        end
        default: step = 1'b0;
      endcase
    end
    if (step && phase == PH_READY) begin
      dir = positive;
    end else begin
      case (phase_next)
        PH_PULL1, PH_SETTLE2, PH_PULL2: dir = 1'b1;
        PH_READY:                       dir = tgt_pos_next > cur_pos_next;
        default:                        dir = 1'b0;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SEEK;
      cur_pos     <= '0;
      tgt_pos     <= '0;
      tick_cnt    <= TMR_MAX;
      pulloff_cnt <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      cur_pos     <= cur_pos_next;
      tgt_pos     <= tgt_pos_next;
      tick_cnt    <= tick_cnt_next;
      pulloff_cnt <= pulloff_cnt_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item.step_pulse      <= step;
      out_item.dir_level       <= dir ^ cfg.dir_flip;
      out_item.is_homed        <= (phase_next == PH_READY);
      out_item.homing_phase    <= phase_next;
      out_item.position_steps  <= cur_pos_next;
      out_item.target_position <= tgt_pos_next;
    end
  end

`ifndef SYNTHESIS
  // Homed flag agrees with the reported phase
  a_homed_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.is_homed == (out_item.homing_phase == PH_READY)))
    else $error("is_homed disagrees with homing_phase");

  // Position and target are untouched until homing ends
  a_pos_before_home: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.is_homed) |->
      (out_item.position_steps == '0 && out_item.target_position == '0))
    else $error("position changed before homing completed");

  // Once homed, the axis stays homed until reset
  a_ready_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_READY) |=> (phase == PH_READY))
    else $error("left ready phase without reset");

  // Every processed item produces a result
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed item produced no result");
`endif

endmodule
